[hw/rtl/envelope_generator_with_loops_assert.svh]
// Assertion macros for the envelope generator with loops.
// Used by the RTL modules that carry concurrent checks; no other dependency.
`ifndef ENVELOPE_GENERATOR_WITH_LOOPS_ASSERT_SVH
`define ENVELOPE_GENERATOR_WITH_LOOPS_ASSERT_SVH
`ifndef SYNTHESIS
`define EGL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("envelope generator check failed");
`define EGL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("envelope generator check failed");
`else
`define EGL_ASSERT(lbl, prop)
`define EGL_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[hw/rtl/egl_pkg.sv]
// Shared types and constants of the envelope generator with loops.
// No dependencies; used by egl_front, egl_back and the top level.
package egl_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int TICK_W     = 16;
  localparam int LEVEL_W    = 16;
  localparam int TT_W       = TICK_W + FRAC_BITS;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int QDEPTH     = 2;

  localparam logic [1:0] ACT_WRITE    = 2'd0;
  localparam logic [1:0] ACT_NOTE_ON  = 2'd1;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd2;
  localparam logic [1:0] ACT_QUERY    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ON       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_START    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_STOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_ON    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_START = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_STOP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_TOTAL    = 3'd7;

  localparam logic [23:0] TICK_RATE_RESET  = 24'h010000;
  localparam logic [5:0]  NODE_TOTAL_RESET = 6'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_QUERY
  } op_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [4:0]         entry_index;
    logic [15:0]        entry_tick;
    logic signed [15:0] entry_level;
    logic [39:0]        sample_pos;
  } in_t;

  typedef struct packed {
    logic signed [15:0] level;
    logic               finished;
  } out_t;

  typedef struct packed {
    logic        loop_on;
    logic [15:0] loop_start;
    logic [15:0] loop_stop;
    logic        sustain_on;
    logic [15:0] sustain_start;
    logic [15:0] sustain_stop;
    logic [23:0] tick_rate;
    logic [5:0]  node_total;
  } cfg_t;

  typedef struct packed {
    op_t op;
    in_t item;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } head_t;

endpackage

[hw/rtl/egl_front.sv]
// Front end: accepts transactions, classifies the action, queues them.
// Depends on egl_pkg.
module egl_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  egl_pkg::in_t   item,
  input  logic           pop,
  output egl_pkg::head_t head
);

  localparam int QAW = $clog2(egl_pkg::QDEPTH);
  localparam int QCW = $clog2(egl_pkg::QDEPTH + 1);

  egl_pkg::qent_t q [egl_pkg::QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           push;
  egl_pkg::qent_t ent_in;

  always_comb begin
    ent_in.item = item;
    case (item.action)
      egl_pkg::ACT_WRITE:    ent_in.op = egl_pkg::OP_WRITE;
      egl_pkg::ACT_NOTE_ON:  ent_in.op = egl_pkg::OP_NOTE_ON;
      egl_pkg::ACT_NOTE_OFF: ent_in.op = egl_pkg::OP_NOTE_OFF;
      default:               ent_in.op = egl_pkg::OP_QUERY;
    endcase
  end

  assign busy       = (count == QCW'(egl_pkg::QDEPTH));
  assign push       = start && !busy;
  assign head.valid = (count != '0);
  assign head.ent   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= ent_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(egl_pkg::QDEPTH - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(egl_pkg::QDEPTH - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/egl_back.sv]
// Back end: node memory, tick scaling, loop folding, node walk, interpolation.
// Depends on egl_pkg and envelope_generator_with_loops_assert.svh.
`include "envelope_generator_with_loops_assert.svh"
module egl_back #(
  parameter int MAX_NODES = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  egl_pkg::cfg_t  cfg,
  input  egl_pkg::head_t head,
  output logic           pop,
  output logic           done,
  output egl_pkg::out_t  result
);

  localparam int AW   = $clog2(MAX_NODES);
  localparam int CW   = AW + 1;
  localparam int TT   = egl_pkg::TT_W;
  localparam int FB   = egl_pkg::FRAC_BITS;
  localparam int DIVW = 50;
  localparam int REMW = TT + 1;
  localparam int DCW  = $clog2(DIVW + 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MUL0   = 5'd1;
  localparam logic [4:0] S_MUL1   = 5'd2;
  localparam logic [4:0] S_SCALE  = 5'd3;
  localparam logic [4:0] S_DISP   = 5'd4;
  localparam logic [4:0] S_DIV    = 5'd5;
  localparam logic [4:0] S_FOLDE  = 5'd6;
  localparam logic [4:0] S_POST   = 5'd7;
  localparam logic [4:0] S_LAST_W = 5'd8;
  localparam logic [4:0] S_LAST_C = 5'd9;
  localparam logic [4:0] S_P0_W   = 5'd10;
  localparam logic [4:0] S_P0_C   = 5'd11;
  localparam logic [4:0] S_WALK_W = 5'd12;
  localparam logic [4:0] S_WALK_C = 5'd13;
  localparam logic [4:0] S_INTERP = 5'd14;
  localparam logic [4:0] S_IMUL   = 5'd15;
  localparam logic [4:0] S_IADJ   = 5'd16;
  localparam logic [4:0] S_LEVEL  = 5'd17;
  localparam logic [4:0] S_OUT    = 5'd18;
  localparam logic [4:0] S_DL1_A  = 5'd19;
  localparam logic [4:0] S_DL1_W  = 5'd20;
  localparam logic [4:0] S_DL1_C  = 5'd21;
  localparam logic [4:0] S_DL2_A  = 5'd22;
  localparam logic [4:0] S_DL2_W  = 5'd23;
  localparam logic [4:0] S_DL2_C  = 5'd24;

  logic [4:0]     state;
  egl_pkg::qent_t cur;
  logic           held;
  logic           live;
  logic [TT-1:0]  shift;
  logic [43:0]    mul_lo;
  logic [43:0]    mul_hi;
  logic [63:0]    scale_sum;
  logic [TT-1:0]  tick;
  logic [TT-1:0]  rtick;
  logic [TT-1:0]  pv;
  logic [TT-1:0]  fold_s;
  logic           fin;
  logic [31:0]    mem [MAX_NODES];
  logic [AW-1:0]  rd_addr;
  logic [31:0]    rdata;
  logic [AW-1:0]  idx;
  logic [31:0]    prevn;
  logic [31:0]    curn;
  logic [TT-1:0]  off;
  logic [TT-1:0]  span;
  logic [16:0]    mag;
  logic           neg;
  logic [48:0]    prod;
  logic [DIVW-1:0] div_num;
  logic [TT-1:0]  div_den;
  logic [REMW-1:0] div_rem;
  logic [DCW-1:0] div_cnt;
  logic           div_fold;
  logic [15:0]    lvl;
  logic [CW-1:0]  cnt;
  logic [AW-1:0]  last;
  logic [TT-1:0]  rp;
  logic [TT-1:0]  fx;
  logic [15:0]    fs;
  logic [15:0]    fe;
  logic           fchk;
  logic           need_fold;
  logic [REMW-1:0] trial;
  logic           ge;
  logic [TT-1:0]  at;
  logic [TT-1:0]  bt;
  logic [TT-1:0]  tc;
  logic signed [16:0] diff;

  always_comb begin
    if (cfg.node_total < 6'd2) begin
      cnt = CW'(2);
    end else if (int'(cfg.node_total) > MAX_NODES) begin
      cnt = CW'(MAX_NODES);
    end else begin
      cnt = CW'(cfg.node_total);
    end
    last = AW'(cnt - CW'(1));
  end

  assign scale_sum = {20'b0, mul_lo} + {mul_hi, 20'b0};

  always_comb begin
    rp = (tick > shift) ? tick - shift : '0;
    if (cur.op == egl_pkg::OP_NOTE_OFF || held) begin
      fx   = tick;
      fs   = cfg.sustain_start;
      fe   = cfg.sustain_stop;
      fchk = 1'b1;
    end else begin
      fx   = rp;
      fs   = cfg.loop_start;
      fe   = cfg.loop_stop;
      fchk = live;
    end
    need_fold = fchk && (fx > {fe, 16'b0});
  end

  always_comb begin
    trial = {div_rem[REMW-2:0], div_num[DIVW-1]};
    ge    = (trial >= {1'b0, div_den});
  end

  always_comb begin
    at   = {prevn[31:16], 16'b0};
    bt   = {curn[31:16], 16'b0};
    tc   = (rtick > bt) ? bt : rtick;
    diff = {curn[15], curn[15:0]} - {prevn[15], prevn[15:0]};
  end

  assign pop = (state == S_IDLE) && head.valid;

  always_ff @(posedge clk) begin
    if (pop && head.ent.op == egl_pkg::OP_WRITE &&
        int'(head.ent.item.entry_index) < MAX_NODES) begin
      mem[AW'(head.ent.item.entry_index)] <=
        {head.ent.item.entry_tick, head.ent.item.entry_level};
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held  <= 1'b0;
      live  <= 1'b0;
      shift <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            cur <= head.ent;
            case (head.ent.op)
              egl_pkg::OP_WRITE: state <= S_IDLE;
              egl_pkg::OP_NOTE_ON: begin
                held  <= cfg.sustain_on;
                shift <= '0;
                live  <= cfg.loop_on;
                idx   <= '0;
                state <= cfg.loop_on ? S_DL1_A : S_IDLE;
              end
              default: state <= S_MUL0;
            endcase
          end
        end
        S_MUL0: begin
          mul_lo <= cur.item.sample_pos[19:0] * cfg.tick_rate;
          state  <= S_MUL1;
        end
        S_MUL1: begin
          mul_hi <= cur.item.sample_pos[39:20] * cfg.tick_rate;
          state  <= S_SCALE;
        end
        S_SCALE: begin
          tick  <= (scale_sum[63:48] != '0) ? '1 : scale_sum[47:16];
          state <= S_DISP;
        end
        S_DISP: begin
          pv     <= cfg.sustain_on ? rp : tick;
          fold_s <= {fs, 16'b0};
          if (cur.op == egl_pkg::OP_NOTE_OFF && !held) begin
            state <= S_IDLE;
          end else if (need_fold && fe <= fs) begin
            rtick <= {fs, 16'b0};
            state <= S_POST;
          end else if (need_fold) begin
            div_num  <= DIVW'(fx - {fs, 16'b0});
            div_den  <= {fe - fs, 16'b0};
            div_rem  <= '0;
            div_cnt  <= '0;
            div_fold <= 1'b1;
            state    <= S_DIV;
          end else begin
            rtick <= fx;
            state <= S_POST;
          end
        end
        S_DIV: begin
          div_rem <= ge ? trial - {1'b0, div_den} : trial;
          div_num <= {div_num[DIVW-2:0], ge};
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(DIVW - 1)) begin
            state <= div_fold ? S_FOLDE : S_LEVEL;
          end
        end
        S_FOLDE: begin
          rtick <= fold_s + div_rem[TT-1:0];
          state <= S_POST;
        end
        S_POST: begin
          if (cur.op == egl_pkg::OP_NOTE_OFF) begin
            shift <= tick - rtick;
            held  <= 1'b0;
            state <= S_IDLE;
          end else begin
            rd_addr <= last;
            state   <= S_LAST_W;
          end
        end
        S_LAST_W: state <= S_LAST_C;
        S_LAST_C: begin
          fin     <= !held && !live && (pv > {rdata[31:16], 16'b0});
          rd_addr <= '0;
          state   <= S_P0_W;
        end
        S_P0_W: state <= S_P0_C;
        S_P0_C: begin
          prevn   <= rdata;
          idx     <= AW'(1);
          rd_addr <= AW'(1);
          state   <= S_WALK_W;
        end
        S_WALK_W: state <= S_WALK_C;
        S_WALK_C: begin
          if (idx != last && rtick > {rdata[31:16], 16'b0}) begin
            prevn   <= rdata;
            idx     <= idx + AW'(1);
            rd_addr <= idx + AW'(1);
            state   <= S_WALK_W;
          end else begin
            curn  <= rdata;
            state <= S_INTERP;
          end
        end
        S_INTERP: begin
          if (curn[31:16] <= prevn[31:16]) begin
            lvl   <= curn[15:0];
            state <= S_OUT;
          end else begin
            off   <= (tc > at) ? tc - at : '0;
            span  <= bt - at;
            neg   <= diff[16];
            mag   <= diff[16] ? 17'(-diff) : 17'(diff);
            state <= S_IMUL;
          end
        end
        S_IMUL: begin
          prod  <= mag * off;
          state <= S_IADJ;
        end
        S_IADJ: begin
          div_num  <= neg ? DIVW'(prod) + DIVW'(span) - DIVW'(1) : DIVW'(prod);
          div_den  <= span;
          div_rem  <= '0;
          div_cnt  <= '0;
          div_fold <= 1'b0;
          state    <= S_DIV;
        end
        S_LEVEL: begin
          lvl   <= neg ? prevn[15:0] - div_num[15:0] : prevn[15:0] + div_num[15:0];
          state <= S_OUT;
        end
        S_OUT: begin
          result.level    <= lvl;
          result.finished <= fin;
          done            <= 1'b1;
          state           <= S_IDLE;
        end
        S_DL1_A: begin
          if (idx != last) begin
            rd_addr <= idx + AW'(1);
            state   <= S_DL1_W;
          end else begin
            state <= S_DL2_A;
          end
        end
        S_DL1_W: state <= S_DL1_C;
        S_DL1_C: begin
          if (rdata[31:16] <= cfg.loop_start) begin
            idx   <= idx + AW'(1);
            state <= S_DL1_A;
          end else begin
            state <= S_DL2_A;
          end
        end
        S_DL2_A: begin
          rd_addr <= idx;
          state   <= S_DL2_W;
        end
        S_DL2_W: state <= S_DL2_C;
        S_DL2_C: begin
          if (rdata[31:16] <= cfg.loop_stop) begin
            if (rdata[15:0] != '0) begin
              state <= S_IDLE;
            end else if (idx == last) begin
              live  <= 1'b0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_DL2_A;
            end
          end else begin
            live  <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `EGL_ASSERT(a_done_pulse, done |=> !done)
  `EGL_ASSERT_IMP(a_done_idle, done, state == S_IDLE)
  `EGL_ASSERT_IMP(a_div_bound, state == S_DIV, div_cnt < DCW'(DIVW))
  `EGL_ASSERT_IMP(a_walk_idx, state == S_WALK_C, idx <= last)

endmodule

[hw/rtl/envelope_generator_with_loops.sv]
// Top level of the envelope generator with loops.
// Depends on egl_pkg, egl_front and egl_back.
//
// Usage: items enter on item when start is high and busy is low; a two-deep
// queue in front lets a new item be taken while the previous one is worked.
// Register writes use cfg_we / cfg_index / cfg_data and are taken at once;
// write them only while the block is idle.
// Each query gives one result on result, valid for the single cycle in which
// done is high; the receiver cannot stall, so results are never held back.
// Write-node items are stored as they leave the queue. Note on scans nodes
// one read at a time, set by the single node memory read port. Note off
// adds a pass of the divider when the tick folds into the sustain loop. A
// query's time is set by the tick scale multiplier, the bit-serial divider
// and the memory port, which is read once per node walked.
// Reset clears the queue, the note state and the registers to their defaults;
// node entries hold no reset value and must be written before use.
module envelope_generator_with_loops #(
  parameter int MAX_NODES = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  egl_pkg::in_t                        item,
  output logic                                done,
  output egl_pkg::out_t                       result,
  input  logic                                cfg_we,
  input  logic [egl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [egl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  egl_pkg::cfg_t  cfg;
  egl_pkg::head_t head;
  logic           pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loop_on       <= 1'b0;
      cfg.loop_start    <= '0;
      cfg.loop_stop     <= '0;
      cfg.sustain_on    <= 1'b0;
      cfg.sustain_start <= '0;
      cfg.sustain_stop  <= '0;
      cfg.tick_rate     <= egl_pkg::TICK_RATE_RESET;
      cfg.node_total    <= egl_pkg::NODE_TOTAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        egl_pkg::REG_LOOP_ON:       cfg.loop_on       <= cfg_data[0];
        egl_pkg::REG_LOOP_START:    cfg.loop_start    <= cfg_data[15:0];
        egl_pkg::REG_LOOP_STOP:     cfg.loop_stop     <= cfg_data[15:0];
        egl_pkg::REG_SUSTAIN_ON:    cfg.sustain_on    <= cfg_data[0];
        egl_pkg::REG_SUSTAIN_START: cfg.sustain_start <= cfg_data[15:0];
        egl_pkg::REG_SUSTAIN_STOP:  cfg.sustain_stop  <= cfg_data[15:0];
        egl_pkg::REG_TICK_RATE:     cfg.tick_rate     <= cfg_data[23:0];
        egl_pkg::REG_NODE_TOTAL:    cfg.node_total    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  egl_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .pop   (pop),
    .head  (head)
  );

  egl_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule
